// File: rtl/mm4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and widths for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int WORD_W = 32;         // one Q16.16 element
    localparam int PROD_W = 2 * WORD_W; // one Q32.32 product
    localparam int NCOLS  = 4;          // elements carried by one transfer

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;

    // Pipeline tag that travels with one product row.
    typedef struct packed {
        logic       vld;
        logic [1:0] row;
        logic       last;
    } t_tag;

endpackage

// File: rtl/matrix_multiply_4x4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// Signed Q16.16 DIM x DIM matrix multiplier with row loads and row results.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       sink       i_in_valid / o_in_stall  operation, row_index, 4 columns
//  out      source     o_out_valid / i_out_stall out_row, 4 columns, flags
//
//  A multiply transfer issues min(DIM,4) product rows (4 by default): while
//  the output is not stalled, the multiplier banks read one left row per cycle,
//  so one product row enters the lanes per cycle. Rows reach the output
//  through the product, sum and output registers.
//  Reset (synchronous) clears both stores and all valid flags.
//  A stalled output freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 #(
    parameter int FRAC_BITS = 16,
    parameter int DIM       = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_operation,
    input  logic [1:0]     i_row_index,
    input  mm4_pkg::t_word i_in_col0,
    input  mm4_pkg::t_word i_in_col1,
    input  mm4_pkg::t_word i_in_col2,
    input  mm4_pkg::t_word i_in_col3,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [1:0]     o_out_row,
    output mm4_pkg::t_word o_out_col0,
    output mm4_pkg::t_word o_out_col1,
    output mm4_pkg::t_word o_out_col2,
    output mm4_pkg::t_word o_out_col3,
    output logic           o_row_saturated,
    output logic           o_last_row
);
    import mm4_pkg::*;

    // Only min(DIM,4) rows and columns can ever be loaded; the rest of a
    // DIM x DIM store stays zero and adds nothing, so it is not built.
    localparam int NL = (DIM < NCOLS) ? DIM : NCOLS;
    localparam int RW = $clog2(NL);

    localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] OP_MULTIPLY   = 2'd2;

    t_word r_left  [NL][NL];
    t_word r_right [NL][NL];

    logic          r_busy;     // rows 1.. of a multiply still to issue
    logic [RW-1:0] r_row;
    t_tag          r_tag1;
    t_tag          r_tag2;

    t_word         w_in_col [NCOLS];
    logic          w_adv;
    logic          w_accept;
    logic          w_row_ok;
    logic          w_issue;
    logic [RW-1:0] w_issue_row;
    logic          w_issue_last;

    t_word         w_col  [NCOLS][NL];
    t_word         w_elem [NCOLS];
    logic [NCOLS-1:0] w_sat;
    t_word         w_out_col [NCOLS];

    assign w_in_col[0] = i_in_col0;
    assign w_in_col[1] = i_in_col1;
    assign w_in_col[2] = i_in_col2;
    assign w_in_col[3] = i_in_col3;

    // The pipeline moves as a whole whenever the output register is free.
    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_busy || !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_row_ok   = {1'b0, i_row_index} < 3'(NL);

    // Row 0 issues in the cycle of the multiply transfer itself.
    assign w_issue      = w_adv && (r_busy || (w_accept && i_operation == OP_MULTIPLY));
    assign w_issue_row  = r_busy ? r_row : '0;
    assign w_issue_last = w_issue_row == RW'(NL - 1);

    // ---- matrix stores ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NL; r++) begin
                for (int c = 0; c < NL; c++) begin
                    r_left[r][c]  <= '0;
                    r_right[r][c] <= '0;
                end
            end
        end else if (w_accept && w_row_ok) begin
            for (int c = 0; c < NL; c++) begin
                if (i_operation == OP_LOAD_LEFT) begin
                    r_left[i_row_index[RW-1:0]][c] <= w_in_col[c];
                end else if (i_operation == OP_LOAD_RIGHT) begin
                    r_right[i_row_index[RW-1:0]][c] <= w_in_col[c];
                end
            end
        end
    end

    // ---- row sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (w_issue) begin
            r_busy <= !w_issue_last;
            r_row  <= w_issue_row + RW'(1);
        end
    end

    // tags follow the products and the sums through the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else if (w_adv) begin
            r_tag1 <= '{vld: w_issue, row: 2'(w_issue_row), last: w_issue_last};
            r_tag2 <= r_tag1;
        end
    end

    // ---- lanes, one per product column ----
    for (genvar j = 0; j < NCOLS; j++) begin : g_lane
        if (j < NL) begin : g_on
            for (genvar k = 0; k < NL; k++) begin : g_col
                assign w_col[j][k] = r_right[k][j];
            end

            mm4_lane #(
                .NL        (NL),
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .i_clk  (i_clk),
                .i_en   (w_adv),
                .i_a    (r_left[w_issue_row]),
                .i_b    (w_col[j]),
                .o_elem (w_elem[j]),
                .o_sat  (w_sat[j])
            );
        end else begin : g_off
            // columns beyond DIM read as zero
            for (genvar k = 0; k < NL; k++) begin : g_col
                assign w_col[j][k] = '0;
            end
            assign w_elem[j] = w_col[j][0];
            assign w_sat[j]  = 1'b0;
        end
    end

    mm4_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_tag   (r_tag2),
        .i_elem  (w_elem),
        .i_sat   (w_sat),
        .o_valid (o_out_valid),
        .o_row   (o_out_row),
        .o_col   (w_out_col),
        .o_sat   (o_row_saturated),
        .o_last  (o_last_row)
    );

    assign o_out_col0 = w_out_col[0];
    assign o_out_col1 = w_out_col[1];
    assign o_out_col2 = w_out_col[2];
    assign o_out_col3 = w_out_col[3];

endmodule

// File: rtl/mm4_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_lane
// One dot-product lane: multiplier bank, summing stage, shift and saturate.
// ----------------------------------------------------------------------------
module mm4_lane #(
    parameter int NL        = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  mm4_pkg::t_word i_a [NL],
    input  mm4_pkg::t_word i_b [NL],
    output mm4_pkg::t_word o_elem,
    output logic          o_sat
);
    import mm4_pkg::*;

    // exact sum of NL products plus a sign bit of headroom
    localparam int SUM_W = PROD_W + $clog2(NL) + 1;

    t_prod                   r_prod [NL];
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] w_shifted;
    logic [SUM_W-32:0]       w_upper;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NL; k++) begin
                r_prod[k] <= PROD_W'(i_a[k]) * PROD_W'(i_b[k]);
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NL; k++) begin
            n_sum = n_sum + SUM_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign w_shifted = r_sum >>> FRAC_BITS;
    assign w_upper   = w_shifted[SUM_W-1:31];

    always_comb begin
        if (w_upper == '0 || w_upper == '1) begin
            o_elem = w_shifted[31:0];
            o_sat  = 1'b0;
        end else if (w_shifted[SUM_W-1]) begin
            o_elem = 32'sh8000_0000;
            o_sat  = 1'b1;
        end else begin
            o_elem = 32'sh7FFF_FFFF;
            o_sat  = 1'b1;
        end
    end

endmodule

// File: rtl/mm4_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_merge
// Gathers the lane results into one product row and holds the output register.
// ----------------------------------------------------------------------------
module mm4_merge (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  mm4_pkg::t_tag  i_tag,
    input  mm4_pkg::t_word i_elem [mm4_pkg::NCOLS],
    input  logic [mm4_pkg::NCOLS-1:0] i_sat,
    output logic           o_valid,
    output logic [1:0]     o_row,
    output mm4_pkg::t_word o_col [mm4_pkg::NCOLS],
    output logic           o_sat,
    output logic           o_last
);
    import mm4_pkg::*;

    logic  r_valid;
    logic  [1:0] r_row;
    t_word r_col [NCOLS];
    logic  r_sat;
    logic  r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_row  <= i_tag.row;
            r_last <= i_tag.last;
            r_sat  <= |i_sat;
            for (int j = 0; j < NCOLS; j++) begin
                r_col[j] <= i_elem[j];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;
    assign o_sat   = r_sat;
    assign o_last  = r_last;
    assign o_col   = r_col;

endmodule

// File: rtl/mm4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks for the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mm4_checker #(
    parameter int DIM = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_operation,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_out_row,
    input logic [31:0] o_out_col0,
    input logic [31:0] o_out_col3,
    input logic        o_last_row
);
    localparam int NL = (DIM < 4) ? DIM : 4;
    localparam logic [1:0] OP_MULTIPLY = 2'd2;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_row) && $stable(o_out_col0) && $stable(o_last_row))
        else $error("stalled output transfer changed");

    // the last flag marks exactly the final product row
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_row == (o_out_row == 2'(NL - 1))))
        else $error("last_row does not match the final row index");

    // a multiply keeps the input stalled while its remaining rows issue
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_operation == OP_MULTIPLY |=> o_in_stall)
        else $error("input taken while product rows still issuing");

    // an unused column 3 (DIM below 4) reads as zero
    a_unused_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (DIM > 3 || o_out_col3 == 32'd0))
        else $error("unused product column not zero");

endmodule

bind matrix_multiply_4x4 mm4_checker #(.DIM(DIM)) u_mm4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_operation (i_operation),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_row   (o_out_row),
    .o_out_col0  (o_out_col0),
    .o_out_col3  (o_out_col3),
    .o_last_row  (o_last_row)
);
